// ===== sv/dlq_pkg.sv =====
// dlq_pkg: shared constants, codes and types of the delta-list timer queue
// used by every module of the block

package dlq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int KEY_BITS    = 16;
  localparam int KEY_W       = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int IDX_W       = $clog2(TIMER_SLOTS + 1);
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(TIMER_SLOTS);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_CAN  = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [31:0]      ticks;
    logic [KEY_W-1:0] key;
    logic             key_zero;
  } item_t;

endpackage

// ===== sv/dlq_front.sv =====
// dlq_front: accepts requests, classifies them and holds them in a short queue
// depends on dlq_pkg

module dlq_front import dlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_elapsed_ticks,
  input  logic [31:0] in_delay_ticks,
  input  logic [15:0] in_timer_key,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t             q_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  item_t             cls;
  logic              push;

  always_comb begin
    cls.key      = in_timer_key[KEY_W-1:0];
    cls.key_zero = (in_timer_key[KEY_W-1:0] == '0);
    cls.ticks    = in_delay_ticks;
    case (in_action)
      ACT_TICK: begin
        cls.op    = OP_TICK;
        cls.ticks = in_elapsed_ticks;
      end
      ACT_ADD:    cls.op = OP_ADD;
      ACT_CANCEL: cls.op = OP_CAN;
      default:    cls.op = OP_BAD;
    endcase
  end

  assign busy    = (cnt_r == QCNT_W'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wr_r] <= cls;
        wr_r      <= (wr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_r <= (rd_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(q_pop && q_valid);
    end
  end

endmodule

// ===== sv/dlq_back.sv =====
// dlq_back: slot table, pending and free lists, list walks and result sequencing
// depends on dlq_pkg

module dlq_back import dlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic        out_ok,
  output logic [15:0] out_fired_key,
  output logic        out_last,
  output logic [4:0]  out_active_count,
  output logic [7:0]  out_dropped_count
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TDEC = 6'b000010,
    ST_TCHK = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_CAN  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] nxt_r [TIMER_SLOTS];
  logic [31:0]      dly_r [TIMER_SLOTS];
  logic [KEY_W-1:0] key_r [TIMER_SLOTS];
  logic [KEY_W-1:0] buf_r [TIMER_SLOTS-1];
  logic [IDX_W-1:0] head_r, free_r, cur_r, prev_r, s_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       drop_r;
  logic [31:0]      rem_r;
  logic [KEY_W-1:0] skey_r;
  logic [SLOT_W-1:0] n_r, e_r;
  logic [1:0]       res_kind_r;
  logic             res_ok_r;

  logic             out_valid_r, out_ok_r, out_last_r;
  logic [1:0]       out_kind_r;
  logic [KEY_W-1:0] out_key_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [7:0]       out_drop_r;

  logic [SLOT_W-1:0] hd_i, cur_i, prev_i, s_i, free_i, nx_i;
  logic              hd_ok, cur_ok, prev_ok, free_ok, nx_ok, emit_last;
  logic [31:0]       hd_dly, cur_dly;
  logic [IDX_W-1:0]  cur_nx;

  always_comb begin
    hd_i      = head_r[SLOT_W-1:0];
    cur_i     = cur_r[SLOT_W-1:0];
    prev_i    = prev_r[SLOT_W-1:0];
    s_i       = s_r[SLOT_W-1:0];
    free_i    = free_r[SLOT_W-1:0];
    hd_ok     = head_r < NONE_IDX;
    cur_ok    = cur_r < NONE_IDX;
    prev_ok   = prev_r < NONE_IDX;
    free_ok   = free_r < NONE_IDX;
    hd_dly    = dly_r[hd_i];
    cur_dly   = dly_r[cur_i];
    cur_nx    = nxt_r[cur_i];
    nx_i      = cur_nx[SLOT_W-1:0];
    nx_ok     = cur_nx < NONE_IDX;
    emit_last = (n_r == '0) || (e_r == n_r - 1'b1);
  end

  assign q_pop = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NONE_IDX;
      free_r      <= '0;
      cnt_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        nxt_r[i] <= (i == TIMER_SLOTS - 1) ? NONE_IDX : IDX_W'(i + 1);
      end
    end else begin
      out_valid_r <= (state_r == ST_EMIT);
      case (state_r)
        ST_IDLE: begin
          n_r <= '0;
          e_r <= '0;
          res_kind_r <= (q_item.op == OP_TICK) ? KIND_NONE : KIND_STATUS;
          res_ok_r   <= (q_item.op == OP_TICK);
          cur_r      <= head_r;
          prev_r     <= NONE_IDX;
          rem_r      <= q_item.ticks;
          skey_r     <= q_item.key;
          if (q_valid) begin
            case (q_item.op)
              OP_TICK: state_r <= ST_TDEC;
              OP_ADD: begin
                if (q_item.key_zero || !free_ok) begin
                  state_r <= ST_EMIT;
                end else begin
                  s_r           <= free_r;
                  free_r        <= nxt_r[free_i];
                  key_r[free_i] <= q_item.key;
                  state_r       <= ST_ADD;
                end
              end
              OP_CAN: state_r <= q_item.key_zero ? ST_EMIT : ST_CAN;
              default: state_r <= ST_EMIT;
            endcase
          end
        end
        ST_TDEC: begin
          if (hd_ok) begin
            dly_r[hd_i] <= (hd_dly > rem_r) ? hd_dly - rem_r : '0;
            state_r     <= ST_TCHK;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_TCHK: begin
          if (hd_ok && hd_dly == '0) begin
            if (n_r < SLOT_W'(TIMER_SLOTS - 1)) begin
              buf_r[n_r] <= key_r[hd_i];
              n_r        <= n_r + 1'b1;
            end else begin
              drop_r <= drop_r + 8'd1;
            end
            head_r      <= nxt_r[hd_i];
            nxt_r[hd_i] <= free_r;
            free_r      <= head_r;
            cnt_r       <= cnt_r - 1'b1;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_ADD: begin
          if (cur_ok && cur_dly <= rem_r) begin
            rem_r  <= rem_r - cur_dly;
            prev_r <= cur_r;
            cur_r  <= cur_nx;
          end else begin
            dly_r[s_i] <= rem_r;
            if (cur_ok) dly_r[cur_i] <= cur_dly - rem_r;
            nxt_r[s_i] <= cur_r;
            if (prev_ok) nxt_r[prev_i] <= s_r;
            else head_r <= s_r;
            cnt_r    <= cnt_r + 1'b1;
            res_ok_r <= 1'b1;
            state_r  <= ST_EMIT;
          end
        end
        ST_CAN: begin
          if (!cur_ok) begin
            state_r <= ST_EMIT;
          end else if (key_r[cur_i] == skey_r) begin
            if (nx_ok) dly_r[nx_i] <= dly_r[nx_i] + cur_dly;
            if (prev_ok) nxt_r[prev_i] <= cur_nx;
            else head_r <= cur_nx;
            nxt_r[cur_i] <= free_r;
            free_r       <= cur_r;
            cnt_r        <= cnt_r - 1'b1;
            res_ok_r     <= 1'b1;
            state_r      <= ST_EMIT;
          end else begin
            prev_r <= cur_r;
            cur_r  <= cur_nx;
          end
        end
        ST_EMIT: begin
          out_kind_r  <= (n_r == '0) ? res_kind_r : KIND_FIRED;
          out_ok_r    <= (n_r == '0) ? res_ok_r : 1'b1;
          out_key_r   <= (n_r == '0) ? '0 : buf_r[e_r];
          out_last_r  <= emit_last;
          out_cnt_r   <= cnt_r;
          out_drop_r  <= drop_r;
          if (emit_last) state_r <= ST_IDLE;
          else e_r <= e_r + 1'b1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe        = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_ok            = out_ok_r;
  assign out_fired_key     = 16'(out_key_r);
  assign out_last          = out_last_r;
  assign out_active_count  = 5'(out_cnt_r);
  assign out_dropped_count = out_drop_r;

endmodule

// ===== sv/delta_list_oneshot_timer_queue.sv =====
// delta_list_oneshot_timer_queue: top level of the delta-list timer queue
// depends on dlq_pkg, dlq_front and dlq_back
//
// usage
// - a request is taken when start is high and busy is low; in_action picks
//   tick, add or cancel, with in_elapsed_ticks, in_delay_ticks, in_timer_key
// - a two-entry queue sits between the front and the list engine, so busy
//   rises only when two requests wait
// - each result shows for one cycle with out_strobe high; out_last marks the
//   final result of a request; the receiver cannot stall the block
// - add gives its status after walking w entries of the list (0..15)
// - cancel gives its status after checking w entries before the match (0..15)
// - tick gives its first result after taking off f expiries (0..16),
//   then one result a cycle
// - requests are worked one at a time
// - synchronous reset empties the list, frees all slots and clears counters;
//   the block takes requests in the first cycle after reset

module delta_list_oneshot_timer_queue import dlq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_elapsed_ticks,
  input  logic [31:0] in_delay_ticks,
  input  logic [15:0] in_timer_key,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic        out_ok,
  output logic [15:0] out_fired_key,
  output logic        out_last,
  output logic [4:0]  out_active_count,
  output logic [7:0]  out_dropped_count
);

  logic  q_valid, q_pop;
  item_t q_item;

  dlq_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_elapsed_ticks, .in_delay_ticks, .in_timer_key,
    .q_valid, .q_item, .q_pop
  );

  dlq_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_strobe, .out_kind, .out_ok, .out_fired_key, .out_last,
    .out_active_count, .out_dropped_count
  );

endmodule

// ===== sv/dlq_checker.sv =====
// dlq_checker: port-level checks on the result stream of the timer queue
// depends on dlq_pkg; bound to delta_list_oneshot_timer_queue

module dlq_checker import dlq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_strobe,
  input logic [1:0]  out_kind,
  input logic        out_ok,
  input logic [15:0] out_fired_key,
  input logic        out_last,
  input logic [4:0]  out_active_count,
  input logic [7:0]  out_dropped_count
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KIND_STATUS || out_kind == KIND_NONE) |-> out_last)
    else $error("status or idle tick result not final");

  a_burst_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_kind == KIND_FIRED)
    else $error("fired burst broken");

  a_burst_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> $stable(out_active_count) && $stable(out_dropped_count))
    else $error("counts change within one request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_active_count <= 5'(TIMER_SLOTS))
    else $error("active count out of range");

endmodule

bind delta_list_oneshot_timer_queue dlq_checker u_dlq_checker (
  .clk, .rst_n, .out_strobe, .out_kind, .out_ok, .out_fired_key, .out_last,
  .out_active_count, .out_dropped_count
);
